/* sv/rrqp_pkg.sv */
package rrqp_pkg;

  localparam int SLOTS = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SLOT_FIELD_W = 5;
  localparam int MASK_FIELD_W = 32;
  localparam int COUNT_FIELD_W = 6;
  localparam int CAP_W = 8;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PICK   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

  typedef struct packed {
    logic [1:0]              kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [MASK_FIELD_W-1:0] high_mask;
  } in_t;

  typedef struct packed {
    logic                     picked_valid;
    logic [SLOT_FIELD_W-1:0]  picked_slot;
    logic                     queue_empty;
    logic [COUNT_FIELD_W-1:0] ready_count;
    logic                     slot_present;
  } out_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
    logic pick_hit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic mask_any;
  } status_t;

endpackage

/* sv/rrqp_ctrl.sv */
module rrqp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rrqp_pkg::status_t status,
  output rrqp_pkg::cmd_t    cmd,
  output logic [1:0]        state
);

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      rrqp_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = status.need_scan ? rrqp_pkg::S_SCAN : rrqp_pkg::S_APPLY;
        end
      end
      rrqp_pkg::S_SCAN: begin
        if (status.hit) begin
          cmd.commit = 1'b1;
          cmd.pick_hit = 1'b1;
          state_nxt = rrqp_pkg::S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      rrqp_pkg::S_APPLY: begin
        cmd.commit = 1'b1;
        state_nxt = rrqp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rrqp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrqp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != rrqp_pkg::S_IDLE);
  assign state = state_r;

endmodule

/* sv/rrqp_dp.sv */
module rrqp_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rrqp_pkg::in_t              in_item,
  input  logic                       cfg_we,
  input  logic [rrqp_pkg::CAP_W-1:0] cfg_wdata,
  input  rrqp_pkg::cmd_t             cmd,
  output rrqp_pkg::status_t          status,
  output logic                       out_strobe,
  output rrqp_pkg::out_t             out_item
);

  logic [rrqp_pkg::SLOTS-1:0]  ready_mask_r, ready_mask_nxt;
  logic [rrqp_pkg::CNT_W-1:0]  ready_cnt_r, ready_cnt_nxt;
  logic [rrqp_pkg::SLOT_W-1:0] scan_start_r, scan_start_nxt;
  logic [rrqp_pkg::CAP_W-1:0]  streak_r, streak_nxt;
  logic [rrqp_pkg::CAP_W-1:0]  cap_r;
  rrqp_pkg::in_t               item_r;
  logic [rrqp_pkg::SLOTS-1:0]  scan_mask_r;
  logic [rrqp_pkg::SLOT_W-1:0] idx_r;
  logic                        use_high_r;
  logic                        strobe_r;
  rrqp_pkg::out_t              out_r;

  logic [rrqp_pkg::SLOTS-1:0]  high_pool;
  logic                        use_high;
  logic                        in_range;
  logic [rrqp_pkg::SLOT_W-1:0] sidx;
  logic                        pick_valid;
  logic [rrqp_pkg::SLOT_FIELD_W-1:0] pick_slot;

  assign high_pool = ready_mask_r & in_item.high_mask[rrqp_pkg::SLOTS-1:0];
  assign use_high  = (|high_pool) && (streak_r < cap_r);

  assign status.need_scan = (in_item.kind == rrqp_pkg::KIND_PICK) && (|ready_mask_r);
  assign status.hit       = scan_mask_r[idx_r];
  assign status.mask_any  = |scan_mask_r;

  assign in_range = ({1'b0, item_r.slot} < (rrqp_pkg::SLOT_FIELD_W + 1)'(rrqp_pkg::SLOTS));
  assign sidx     = item_r.slot[rrqp_pkg::SLOT_W-1:0];

  always_comb begin
    ready_mask_nxt = ready_mask_r;
    ready_cnt_nxt  = ready_cnt_r;
    scan_start_nxt = scan_start_r;
    streak_nxt     = streak_r;
    pick_valid     = 1'b0;
    pick_slot      = '0;
    if (cmd.commit) begin
      case (item_r.kind)
        rrqp_pkg::KIND_ADD: begin
          if (in_range && !ready_mask_r[sidx]) begin
            ready_mask_nxt[sidx] = 1'b1;
            ready_cnt_nxt = ready_cnt_r + rrqp_pkg::CNT_W'(1);
          end
        end
        rrqp_pkg::KIND_REMOVE: begin
          if (in_range && ready_mask_r[sidx]) begin
            ready_mask_nxt[sidx] = 1'b0;
            ready_cnt_nxt = ready_cnt_r - rrqp_pkg::CNT_W'(1);
          end
        end
        rrqp_pkg::KIND_PICK: begin
          if (cmd.pick_hit) begin
            pick_valid     = 1'b1;
            pick_slot      = rrqp_pkg::SLOT_FIELD_W'(idx_r);
            scan_start_nxt = idx_r + rrqp_pkg::SLOT_W'(1);
            streak_nxt     = use_high_r ? streak_r + rrqp_pkg::CAP_W'(1) : '0;
          end
        end
        rrqp_pkg::KIND_CLEAR: begin
          ready_mask_nxt = '0;
          ready_cnt_nxt  = '0;
        end
        default: begin
          ready_mask_nxt = ready_mask_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_mask_r <= '0;
      ready_cnt_r  <= '0;
      scan_start_r <= '0;
      streak_r     <= '0;
      cap_r        <= rrqp_pkg::CAP_RESET;
      strobe_r     <= 1'b0;
    end else begin
      ready_mask_r <= ready_mask_nxt;
      ready_cnt_r  <= ready_cnt_nxt;
      scan_start_r <= scan_start_nxt;
      streak_r     <= streak_nxt;
      strobe_r     <= cmd.commit;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_item;
      idx_r       <= scan_start_r;
      use_high_r  <= use_high;
      scan_mask_r <= use_high ? high_pool : ready_mask_r;
    end else if (cmd.advance) begin
      idx_r <= idx_r + rrqp_pkg::SLOT_W'(1);
    end
    if (cmd.commit) begin
      out_r.picked_valid <= pick_valid;
      out_r.picked_slot  <= pick_slot;
      out_r.queue_empty  <= (ready_cnt_nxt == '0);
      out_r.ready_count  <= rrqp_pkg::COUNT_FIELD_W'(ready_cnt_nxt);
      out_r.slot_present <= in_range && ready_mask_nxt[sidx];
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

/* sv/round_robin_run_queue_picker.sv */
// Channel  Handshake            Payload
// input    start / busy         in_item   (kind, slot, high_mask)
// result   out_strobe           out_item  (picked_valid .. slot_present)
// config   cfg_we               cfg_wdata (hipri_cap)
//
// Add, remove and clear go from IDLE to APPLY, where the result is committed and registered.
// A pick on a non-empty queue scans one slot per cycle from the cursor in SCAN; on an empty queue it goes to APPLY.
// A new transfer is taken at the edge that accepts the previous result.
// Synchronous active-low reset empties the queue and sets hipri_cap to 4.
// The result strobe is high for one cycle only; the receiver cannot stall it.
module round_robin_run_queue_picker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  rrqp_pkg::in_t              in_item,
  input  logic                       cfg_we,
  input  logic [rrqp_pkg::CAP_W-1:0] cfg_wdata,
  output logic                       out_strobe,
  output rrqp_pkg::out_t             out_item
);

  rrqp_pkg::cmd_t    cmd;
  rrqp_pkg::status_t status;
  logic [1:0]        state;

  rrqp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd),
    .state  (state)
  );

  rrqp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  a_scan_has_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state == rrqp_pkg::S_SCAN) |-> status.mask_any)
    else $error("scan running over an empty mask");

  a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.picked_valid) |-> !out_item.queue_empty)
    else $error("pick reported with empty queue");
`endif

endmodule
